// ----- rtl/core/hsv_to_rgb_converter_macros.svh -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter assertion macros
// concurrent property wrappers used by the hsvrgb_div stage
// ---------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// same-cycle implication
`define HSVRGB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HSVRGB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/hsvrgb_pkg.sv -----
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// shared widths, defaults and hue sector codes of the HSV to RGB converter
// ---------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HSVRGB_HUE_BITS     = 16;
  localparam int HSVRGB_CHANNEL_BITS = 8;
  localparam int SECTOR_BITS         = 3;

  // sixths of the hue circle
  typedef enum logic [SECTOR_BITS-1:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_t;

endpackage

// ----- rtl/core/hsvrgb_sector.sv -----
// ---------------------------------------------------------------------------
// hsvrgb_sector
// stage 1: splits six times the hue into sector and fractional position
// ---------------------------------------------------------------------------
module hsvrgb_sector
  import hsvrgb_pkg::*;
#(
  parameter int HUE_BITS     = HSVRGB_HUE_BITS,
  parameter int CHANNEL_BITS = HSVRGB_CHANNEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic [HUE_BITS-1:0]     hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] brightness,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output sector_t                 sector,
  output logic [HUE_BITS-1:0]     frac,
  output logic [CHANNEL_BITS-1:0] sat,
  output logic [CHANNEL_BITS-1:0] val
);

  logic [HUE_BITS+2:0] six_hue;

  // 6h as 4h + 2h
  assign six_hue  = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      sector <= sector_t'(six_hue[HUE_BITS+2:HUE_BITS]);
      frac   <= six_hue[HUE_BITS-1:0];
      sat    <= saturation;
      val    <= brightness;
    end
  end

endmodule

// ----- rtl/core/hsvrgb_product.sv -----
// ---------------------------------------------------------------------------
// hsvrgb_product
// stages 2 and 3: saturation by fraction products and v * (M - s), then scaling by value
// ---------------------------------------------------------------------------
module hsvrgb_product
  import hsvrgb_pkg::*;
#(
  parameter int HUE_BITS     = HSVRGB_HUE_BITS,
  parameter int CHANNEL_BITS = HSVRGB_CHANNEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  sector_t                   up_sector,
  input  logic [HUE_BITS-1:0]       frac,
  input  logic [CHANNEL_BITS-1:0]   sat,
  input  logic [CHANNEL_BITS-1:0]   up_val,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output sector_t                   dn_sector,
  output logic [CHANNEL_BITS-1:0]   dn_val,
  output logic [2*CHANNEL_BITS-1:0] p_prod,
  output logic [2*CHANNEL_BITS-1:0] q_prod,
  output logic [2*CHANNEL_BITS-1:0] t_prod
);

  localparam int C  = CHANNEL_BITS;
  localparam int H  = HUE_BITS;
  localparam int CH = C + H;

  localparam logic [C-1:0]  CH_MAX = {C{1'b1}};
  localparam logic [H:0]    HUE_ONE = {1'b1, {H{1'b0}}};
  localparam logic [CH-1:0] MH = {{C{1'b1}}, {H{1'b0}}};

  // stage 2 registers
  logic                 valid2;
  logic                 ready2;
  sector_t              sector2;
  logic [C-1:0]         val2;
  logic [CH-1:0]        sf;
  logic [CH-1:0]        sfc;
  logic [2*C-1:0]       pp2;

  logic [H:0]           frac_c;
  logic [CH:0]          sfc_full;
  logic [2*C+H-1:0]     xq;
  logic [2*C+H-1:0]     xt;

  assign frac_c   = HUE_ONE - {1'b0, frac};
  assign sfc_full = {{(H+1){1'b0}}, sat} * {{C{1'b0}}, frac_c};

  assign up_ready = !valid2 || ready2;
  assign ready2   = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2   <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        valid2 <= up_valid;
      end
      if (ready2) begin
        dn_valid <= valid2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      sector2 <= up_sector;
      val2    <= up_val;
      sf      <= {{H{1'b0}}, sat} * {{C{1'b0}}, frac};
      sfc     <= sfc_full[CH-1:0];   // never above M * 2^H
      pp2     <= {{C{1'b0}}, up_val} * {{C{1'b0}}, CH_MAX - sat};
    end
  end

  // v * (M*2^H - s*f), floored by 2^H ahead of the divide by M
  assign xq = {{(C+H){1'b0}}, val2} * {{C{1'b0}}, MH - sf};
  assign xt = {{(C+H){1'b0}}, val2} * {{C{1'b0}}, MH - sfc};

  always_ff @(posedge clk) begin
    if (ready2) begin
      dn_sector <= sector2;
      dn_val    <= val2;
      p_prod    <= pp2;
      q_prod    <= xq[2*C+H-1:H];
      t_prod    <= xt[2*C+H-1:H];
    end
  end

endmodule

// ----- rtl/core/hsvrgb_div.sv -----
// ---------------------------------------------------------------------------
// hsvrgb_div
// stage 4: divides the three products by the channel maximum 2^C - 1
// ---------------------------------------------------------------------------
module hsvrgb_div
  import hsvrgb_pkg::*;
#(
  parameter int CHANNEL_BITS = HSVRGB_CHANNEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  sector_t                   up_sector,
  input  logic [CHANNEL_BITS-1:0]   up_val,
  input  logic [2*CHANNEL_BITS-1:0] p_prod,
  input  logic [2*CHANNEL_BITS-1:0] q_prod,
  input  logic [2*CHANNEL_BITS-1:0] t_prod,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output sector_t                   dn_sector,
  output logic [CHANNEL_BITS-1:0]   dn_val,
  output logic [CHANNEL_BITS-1:0]   p,
  output logic [CHANNEL_BITS-1:0]   q,
  output logic [CHANNEL_BITS-1:0]   t
);

`include "hsv_to_rgb_converter_macros.svh"

  localparam int C = CHANNEL_BITS;
  localparam logic [C:0] M1 = {1'b0, {C{1'b1}}};
  localparam logic [C:0] M2 = {{C{1'b1}}, 1'b0};

  // y = hi*2^C + lo = hi*M + (hi + lo), remainder below 2M + 2
  function automatic logic [C-1:0] div_max(input logic [2*C-1:0] y);
    logic [C:0] hi;
    logic [C:0] rem;
    logic [C:0] quo;
    hi  = {1'b0, y[2*C-1:C]};
    rem = {1'b0, y[C-1:0]} + hi;
    quo = hi + {{C{1'b0}}, (rem >= M1)} + {{C{1'b0}}, (rem >= M2)};
    return quo[C-1:0];
  endfunction

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_sector <= up_sector;
      dn_val    <= up_val;
      p         <= div_max(p_prod);
      q         <= div_max(q_prod);
      t         <= div_max(t_prod);
    end
  end

  `HSVRGB_ASSERT_IMP(a_bounded_by_value, clk, rst, dn_valid, (p <= dn_val) && (q <= dn_val) && (t <= dn_val), "stage 4 term exceeds value")
  `HSVRGB_ASSERT_IMP(a_p_is_minimum, clk, rst, dn_valid, (p <= q) && (p <= t), "p above q or t")
  `HSVRGB_ASSERT_NXT(a_hold_on_stall, clk, rst, dn_valid && !dn_ready, dn_valid && $stable(p) && $stable(q) && $stable(t), "stage 4 lost data under stall")

endmodule

// ----- rtl/core/hsvrgb_route.sv -----
// ---------------------------------------------------------------------------
// hsvrgb_route
// stage 5: steers v, p, q and t onto red, green and blue by sector
// ---------------------------------------------------------------------------
module hsvrgb_route
  import hsvrgb_pkg::*;
#(
  parameter int CHANNEL_BITS = HSVRGB_CHANNEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  sector_t                 sector,
  input  logic [CHANNEL_BITS-1:0] val,
  input  logic [CHANNEL_BITS-1:0] p,
  input  logic [CHANNEL_BITS-1:0] q,
  input  logic [CHANNEL_BITS-1:0] t,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);

  logic [CHANNEL_BITS-1:0] red_next;
  logic [CHANNEL_BITS-1:0] green_next;
  logic [CHANNEL_BITS-1:0] blue_next;

  always_comb begin
    case (sector)
      SEC_RED_YELLOW: begin
        red_next = val; green_next = t;   blue_next = p;
      end
      SEC_YELLOW_GREEN: begin
        red_next = q;   green_next = val; blue_next = p;
      end
      SEC_GREEN_CYAN: begin
        red_next = p;   green_next = val; blue_next = t;
      end
      SEC_CYAN_BLUE: begin
        red_next = p;   green_next = q;   blue_next = val;
      end
      SEC_BLUE_MAGENTA: begin
        red_next = t;   green_next = p;   blue_next = val;
      end
      default: begin
        red_next = val; green_next = p;   blue_next = q;
      end
    endcase
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

// ----- rtl/core/hsv_to_rgb_converter.sv -----
// ---------------------------------------------------------------------------
// hsv_to_rgb_converter: HSV pixel to RGB pixel, five register stages
// throughput: one pixel per cycle; each stage advances when the next is free
// reset: rst clears all stage valid bits, data registers are not reset
// ---------------------------------------------------------------------------
module hsv_to_rgb_converter
  import hsvrgb_pkg::*;
#(
  parameter int HUE_BITS     = HSVRGB_HUE_BITS,
  parameter int CHANNEL_BITS = HSVRGB_CHANNEL_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    hsv_valid,
  output logic                    hsv_ready,
  input  logic [HUE_BITS-1:0]     hue,
  input  logic [CHANNEL_BITS-1:0] saturation,
  input  logic [CHANNEL_BITS-1:0] brightness,
  output logic                    rgb_valid,
  input  logic                    rgb_ready,
  output logic [CHANNEL_BITS-1:0] red,
  output logic [CHANNEL_BITS-1:0] green,
  output logic [CHANNEL_BITS-1:0] blue
);

  localparam int C = CHANNEL_BITS;

  logic                s1_valid, s1_ready;
  sector_t             s1_sector;
  logic [HUE_BITS-1:0] s1_frac;
  logic [C-1:0]        s1_sat, s1_val;

  logic                s3_valid, s3_ready;
  sector_t             s3_sector;
  logic [C-1:0]        s3_val;
  logic [2*C-1:0]      s3_p, s3_q, s3_t;

  logic                s4_valid, s4_ready;
  sector_t             s4_sector;
  logic [C-1:0]        s4_val, s4_p, s4_q, s4_t;

  hsvrgb_sector #(
    .HUE_BITS     (HUE_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_sector (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (hsv_valid),
    .up_ready   (hsv_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .dn_valid   (s1_valid),
    .dn_ready   (s1_ready),
    .sector     (s1_sector),
    .frac       (s1_frac),
    .sat        (s1_sat),
    .val        (s1_val)
  );

  hsvrgb_product #(
    .HUE_BITS     (HUE_BITS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_product (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s1_valid),
    .up_ready  (s1_ready),
    .up_sector (s1_sector),
    .frac      (s1_frac),
    .sat       (s1_sat),
    .up_val    (s1_val),
    .dn_valid  (s3_valid),
    .dn_ready  (s3_ready),
    .dn_sector (s3_sector),
    .dn_val    (s3_val),
    .p_prod    (s3_p),
    .q_prod    (s3_q),
    .t_prod    (s3_t)
  );

  hsvrgb_div #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (s3_valid),
    .up_ready  (s3_ready),
    .up_sector (s3_sector),
    .up_val    (s3_val),
    .p_prod    (s3_p),
    .q_prod    (s3_q),
    .t_prod    (s3_t),
    .dn_valid  (s4_valid),
    .dn_ready  (s4_ready),
    .dn_sector (s4_sector),
    .dn_val    (s4_val),
    .p         (s4_p),
    .q         (s4_q),
    .t         (s4_t)
  );

  hsvrgb_route #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_route (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s4_valid),
    .up_ready (s4_ready),
    .sector   (s4_sector),
    .val      (s4_val),
    .p        (s4_p),
    .q        (s4_q),
    .t        (s4_t),
    .dn_valid (rgb_valid),
    .dn_ready (rgb_ready),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb: hsv_to_rgb_converter testbench
// streams directed and random hsv pixels through the converter with random
// gaps on the hsv side and random stalls on the rgb side, and checks every
// rgb transaction against a fixed-point prediction in arrival order
// ---------------------------------------------------------------------------
module tb;
  import hsvrgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HB = HSVRGB_HUE_BITS;
  localparam int CB = HSVRGB_CHANNEL_BITS;
  localparam longint unsigned HUE_ONE = 64'd1 << HB;
  localparam longint unsigned CH_MAX  = (64'd1 << CB) - 64'd1;
  localparam int MAX_GAP      = 12;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [HB-1:0] hue;
    logic [CB-1:0] saturation;
    logic [CB-1:0] brightness;
    int            gap;
  } hsv_pixel_t;

  typedef struct {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_pixel_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          hsv_valid = 1'b0;
  logic          hsv_ready;
  logic [HB-1:0] hue = '0;
  logic [CB-1:0] saturation = '0;
  logic [CB-1:0] brightness = '0;
  logic          rgb_valid;
  logic          rgb_ready = 1'b0;
  logic [CB-1:0] red;
  logic [CB-1:0] green;
  logic [CB-1:0] blue;

  hsv_pixel_t pending_pixels[$];
  rgb_pixel_t rgb_due[$];
  int         mismatches = 0;
  int         rgb_count = 0;

  hsv_to_rgb_converter uut (
    .clk        (clk),
    .rst        (rst),
    .hsv_valid  (hsv_valid),
    .hsv_ready  (hsv_ready),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic rgb_pixel_t convert_hsv(input logic [HB-1:0] h,
                                             input logic [CB-1:0] s,
                                             input logic [CB-1:0] v);
    longint unsigned six_h, f, den, sv, vv, p, q, t;
    sector_t         sec;
    rgb_pixel_t      px;
    sv = longint'(s);
    vv = longint'(v);
    if (s == '0) begin
      px = '{v, v, v};
    end else begin
      six_h = longint'(h) * 64'd6;
      sec   = sector_t'(six_h[HB+2:HB]);
      f     = six_h & (HUE_ONE - 64'd1);
      den   = CH_MAX * HUE_ONE;
      p     = (vv * (CH_MAX - sv)) / CH_MAX;
      q     = (vv * (den - sv * f)) / den;
      t     = (vv * (den - sv * (HUE_ONE - f))) / den;
      case (sec)
        SEC_RED_YELLOW:   px = '{v, t[CB-1:0], p[CB-1:0]};
        SEC_YELLOW_GREEN: px = '{q[CB-1:0], v, p[CB-1:0]};
        SEC_GREEN_CYAN:   px = '{p[CB-1:0], v, t[CB-1:0]};
        SEC_CYAN_BLUE:    px = '{p[CB-1:0], q[CB-1:0], v};
        SEC_BLUE_MAGENTA: px = '{t[CB-1:0], p[CB-1:0], v};
        default:          px = '{v, p[CB-1:0], q[CB-1:0]};
      endcase
    end
    return px;
  endfunction

  // mostly uniform, with the edges of the range weighted up
  function automatic logic [CB-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CB'(CH_MAX);
      2: return CB'(1);
      3: return CB'(CH_MAX - 1);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [HB-1:0] pick_hue();
    longint unsigned edge_hue;
    case ($urandom_range(0, 7))
      0: begin
        // close to a sector boundary, either side
        edge_hue = (HUE_ONE * longint'($urandom_range(0, 6))) / 64'd6;
        edge_hue = edge_hue + longint'($urandom_range(0, 4)) - 64'd2;
        return HB'(edge_hue);
      end
      1: return HB'(HUE_ONE - 64'd1 - longint'($urandom_range(0, 3)));
      default: return HB'($urandom);
    endcase
  endfunction

  function automatic int pick_gap(input bit calm);
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic queue_pixel(input logic [HB-1:0] h, input logic [CB-1:0] s,
                             input logic [CB-1:0] v, input bit calm);
    hsv_pixel_t px;
    px.hue        = h;
    px.saturation = s;
    px.brightness = v;
    px.gap        = pick_gap(calm);
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  // hsv side: present one pixel, hold it until the transaction, then idle for its gap, which may be zero
  always @(posedge clk) begin : hsv_driver
    hsv_pixel_t px;
    logic       busy;
    int         gap_left;
    if (rst) begin
      hsv_valid <= 1'b0;
      gap_left = 0;
    end else begin
      busy = hsv_valid;
      if (hsv_valid && hsv_ready) begin
        rgb_due.insert(rgb_due.size(), convert_hsv(hue, saturation, brightness));
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          hsv_valid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          px = pending_pixels.pop_front();
          hsv_valid  <= 1'b1;
          hue        <= px.hue;
          saturation <= px.saturation;
          brightness <= px.brightness;
          gap_left = px.gap;
        end else begin
          hsv_valid <= 1'b0;
        end
      end
    end
  end

  // rgb side: check each transaction, then stall for a random spell
  always @(posedge clk) begin : rgb_monitor
    rgb_pixel_t want;
    int         stall_left;
    bit         calm;
    if (rst) begin
      rgb_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rgb_valid && rgb_ready) begin
        if (rgb_due.size() == 0) begin
          $error("rgb transaction with no pixel outstanding: %0d %0d %0d",
                 red, green, blue);
          mismatches++;
        end else begin
          want = rgb_due.pop_front();
          if (red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, red);
            mismatches++;
          end
          if (green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, green);
            mismatches++;
          end
          if (blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, blue);
            mismatches++;
          end
        end
        rgb_count++;
        calm = ((rgb_count / 128) % 4) == 2;
        stall_left = pick_gap(calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        rgb_ready <= 1'b0;
      end else begin
        rgb_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int         k;
    logic [HB-1:0] sector_start;
    // sector boundaries, both sides, at full saturation and value, plus a mid-sector hue at value 200
    for (k = 0; k < 6; k++) begin
      sector_start = HB'((HUE_ONE * longint'(k) + 64'd5) / 64'd6);
      queue_pixel(sector_start, '1, '1, 1'b0);
      queue_pixel(sector_start + HB'(HUE_ONE / 12), '1, CB'(200), 1'b0);
      if (k != 0) queue_pixel(sector_start - HB'(1), '1, '1, 1'b0);
    end
    // hue just under a full turn, gray, black, tiny channels and alternating bit patterns
    queue_pixel('1, '1, '1, 1'b0);
    queue_pixel('0, '0, '0, 1'b0);
    queue_pixel(HB'(12345), '0, CB'(200), 1'b0);
    queue_pixel(HB'(40000), '0, '1, 1'b0);
    queue_pixel(HB'(30000), '1, '0, 1'b0);
    queue_pixel(HB'(50000), CB'(1), '1, 1'b0);
    queue_pixel(HB'(20000), '1, CB'(1), 1'b0);
    queue_pixel(HB'('h5555), CB'('haa), CB'('h55), 1'b0);
    queue_pixel(HB'('haaaa), CB'('h55), CB'('haa), 1'b0);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      queue_pixel(pick_hue(), pick_channel(), pick_channel(), ((k / 100) % 4) == 1);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_pixels.size() != 0 || hsv_valid) @(posedge clk);
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
